// File: rtl/rqc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue with cancel: shared definitions
// Sizes, the operation codes and the command word broadcast to every cell.
// ----------------------------------------------------------------------------
package rqc_pkg;

   // Number of queue cells and width of one task identifier.
   localparam int DEPTH    = 16;
   localparam int ID_BITS  = 16;
   // The occupancy must be able to hold DEPTH itself.
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   // Operation codes carried on the request opcode field.
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2
   } opcode_type;

   // Command broadcast to all cells in the cycle a word is accepted.
   typedef struct packed {
      logic               add;
      logic               pop;
      logic               remove;
      logic [ID_BITS-1:0] key;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/rqc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue cell
// Holds one identifier, compares it with the broadcast key and either keeps
// it, takes its right-hand neighbor's identifier or loads the key.
// ----------------------------------------------------------------------------
module rqc_cell (
   input  wire                          clock,
   input  wire rqc_pkg::cmd_type        cmd,
   input  wire                          live,      // cell holds a queued entry
   input  wire                          tail,      // first free cell
   input  wire                          hit_in,    // a cell nearer the head matched
   input  wire  [rqc_pkg::ID_BITS-1:0]  next_id,   // identifier of the next cell
   output logic [rqc_pkg::ID_BITS-1:0]  id_out,
   output logic                         hit_out
);

   logic [rqc_pkg::ID_BITS-1:0] id_ff;
   logic [rqc_pkg::ID_BITS-1:0] id_in;
   logic                        match;
   logic                        shift;
   logic                        load;

   // A live entry equal to the key is a match; the hit chain runs toward the tail.
   assign match   = live && (id_ff == cmd.key);
   assign hit_out = hit_in | match;

   // Pop moves every cell up; a removal moves the matching cell and all after it.
   assign shift = cmd.pop | (cmd.remove & hit_out);
   assign load  = cmd.add & tail;

   always_comb begin
      id_in = id_ff;
      if (shift) begin
         id_in = next_id;
      end else if (load) begin
         id_in = cmd.key;
      end
   end

   // The identifier needs no reset: cells beyond the occupancy are never read.
   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id_out = id_ff;

endmodule

`default_nettype wire

// File: rtl/ready_queue_with_cancel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ready queue with cancel
// First-in first-out queue of task identifiers with add, pop and remove by id.
// ----------------------------------------------------------------------------
// The block takes one request word per clock cycle for every opcode and
// returns exactly one response word for each, in the cycle after acceptance,
// from an output register. All work of a request happens in its accepting cycle
// in a row of DEPTH cells: each cell compares its identifier with the key,
// a one-bit hit chain marks the first match from the head, and the cells at
// and after it (all cells on a pop) take their neighbor's identifier. An add
// loads the cell at the occupancy. req_ready is high whenever the output
// register is empty or its word is being taken in the same cycle, so with
// rsp_ready held high the throughput is one word per cycle.
module ready_queue_with_cancel (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_opcode,
   input  wire  [15:0] req_task_id,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_popped_id,
   output logic        rsp_popped_valid,
   output logic        rsp_removed_found,
   output logic [4:0]  rsp_occupancy,
   output logic        rsp_overflow
);

   localparam int DEPTH    = rqc_pkg::DEPTH;
   localparam int ID_BITS  = rqc_pkg::ID_BITS;
   localparam int CNT_BITS = rqc_pkg::CNT_BITS;

   logic                req_fire;
   rqc_pkg::cmd_type    cmd;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic [ID_BITS-1:0]  cell_id [DEPTH];
   logic [DEPTH:0]      hit;
   logic                full;
   logic                empty;
   logic                found;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [15:0]         popped_id_ff;
   logic [15:0]         popped_id_in;
   logic                popped_valid_ff;
   logic                popped_valid_in;
   logic                removed_found_ff;
   logic                removed_found_in;
   logic                overflow_ff;
   logic                overflow_in;
   logic [CNT_BITS-1:0] occ_ff;

   // Accept a new word whenever the output register is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign full  = (count_ff == CNT_BITS'(DEPTH));
   assign empty = (count_ff == '0);

   // Decode the accepted word into the command for the cell row.
   always_comb begin
      cmd.add    = 1'b0;
      cmd.pop    = 1'b0;
      cmd.remove = 1'b0;
      cmd.key    = req_task_id[ID_BITS-1:0];
      if (req_fire) begin
         case (rqc_pkg::opcode_type'(req_opcode))
            rqc_pkg::OP_ADD:    cmd.add    = 1'b1;
            rqc_pkg::OP_POP:    cmd.pop    = 1'b1;
            rqc_pkg::OP_REMOVE: cmd.remove = 1'b1;
            default:            cmd.add    = 1'b0;
         endcase
      end
   end

   // The row of cells, head at index zero.
   assign hit[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ID_BITS-1:0] next_id;
      if (i == DEPTH - 1) begin : g_last
         assign next_id = '0;
      end else begin : g_mid
         assign next_id = cell_id[i+1];
      end

      rqc_cell u_cell (
         .clock   (clock),
         .cmd     (cmd),
         .live    (count_ff > CNT_BITS'(i)),
         .tail    (count_ff == CNT_BITS'(i)),
         .hit_in  (hit[i]),
         .next_id (next_id),
         .id_out  (cell_id[i]),
         .hit_out (hit[i+1])
      );
   end

   assign found = hit[DEPTH];

   // Occupancy update.
   always_comb begin
      count_in = count_ff;
      if (cmd.add && !full) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if ((cmd.pop && !empty) || (cmd.remove && found)) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   // Response word contents.
   always_comb begin
      popped_valid_in  = cmd.pop && !empty;
      popped_id_in     = popped_valid_in ? 16'(cell_id[0]) : 16'd0;
      removed_found_in = cmd.remove && found;
      overflow_in      = cmd.add && full;
      rsp_valid_in     = req_fire || (rsp_valid_ff && !rsp_ready);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload, loaded only when a word is accepted.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         popped_id_ff     <= popped_id_in;
         popped_valid_ff  <= popped_valid_in;
         removed_found_ff <= removed_found_in;
         overflow_ff      <= overflow_in;
      end
   end

   // The occupancy after the accepted word, held for the response.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         occ_ff <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_id     = popped_id_ff;
   assign rsp_popped_valid  = popped_valid_ff;
   assign rsp_removed_found = removed_found_ff;
   assign rsp_occupancy     = 5'(occ_ff);
   assign rsp_overflow      = overflow_ff;

   // Assertions.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue occupancy exceeds depth");

   a_pop_returns: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop && !empty) |=> (rsp_popped_valid && count_ff == $past(count_ff) - CNT_BITS'(1)))
      else $error("pop on a non-empty queue did not return an entry");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.remove && found) |=> (rsp_removed_found
                                 && count_ff == $past(count_ff) - CNT_BITS'(1)))
      else $error("successful remove did not shrink the queue");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_popped_valid, rsp_removed_found, rsp_overflow}) <= 1)
      else $error("more than one outcome flag set in a response");

endmodule

`default_nettype wire
